>>> design/assert_macros.svh
// assertion helper macros for the button debounce click classifier
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BDC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bdc check failed");
// antecedent in one cycle implies consequent in the next
`define BDC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdc check failed");
`else
`define BDC_ASSERT(lbl, clk, rst, prop)
`define BDC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/bdc_pkg.sv
// shared types and constants for the button debounce click classifier
// no dependencies; used by front, queue, back and top level
package bdc_pkg;

   localparam int QDEPTH = 8;
   localparam int QPTR_W = 3;
   localparam int QCNT_W = 4;
   localparam int MAX_EV = 3;

   typedef enum logic [2:0] {
      EV_PRESSED  = 3'd0,
      EV_RELEASED = 3'd1,
      EV_CLICKED  = 3'd2,
      EV_LONG     = 3'd3,
      EV_DOUBLE   = 3'd4,
      EV_TRIPLE   = 3'd5
   } evt_code_type;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_RESYNC = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   localparam logic [2:0] CSR_ACTIVE_HIGH = 3'd0;
   localparam logic [2:0] CSR_DEBOUNCE    = 3'd1;
   localparam logic [2:0] CSR_LONG_CLICK  = 3'd2;
   localparam logic [2:0] CSR_MULTI_CLICK = 3'd3;
   localparam logic [2:0] CSR_TICK_PERIOD = 3'd4;

   typedef struct packed {
      logic        active_high;
      logic [31:0] debounce_ticks;
      logic [31:0] long_click_ticks;
      logic [31:0] multi_click_ticks;
      logic [9:0]  tick_period_ms;
   } cfg_type;

   // data is the final value, or held ticks for a long click
   typedef struct packed {
      logic         last;
      evt_code_type code;
      logic [31:0]  data;
   } evt_type;

   typedef struct packed {
      logic [1:0] push_n;
      logic [1:0] pending;
   } front_status_type;

   function automatic evt_type flush_event(input logic [1:0] pend);
      evt_type e;
      e.last = 1'b0;
      case (pend)
         2'd1: begin
            e.code = EV_CLICKED;
            e.data = 32'd1;
         end
         2'd2: begin
            e.code = EV_DOUBLE;
            e.data = 32'd2;
         end
         default: begin
            e.code = EV_TRIPLE;
            e.data = 32'd3;
         end
      endcase
      return e;
   endfunction

endpackage

>>> design/button_debounce_click_classifier_top.sv
// the first event of an item is written into the event queue when the item is accepted
//   and is then loaded into the output register, from which it is presented
// throughput: one item per cycle while the 8-deep event queue has room for 3;
//   sustained, the rate is set by the single output register draining the queue;
//   an item causes 0 to 3 events
// reset: synchronous, active high; clears debounce state, queue and configuration
//   registers to their defaults; no item is taken while reset is high
`include "assert_macros.svh"

module button_debounce_click_classifier_top #(
   parameter int TICK_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now[31:0], level[32], read_ok[33], zero pad
   input  logic [1:0]  req_tuser,   // command[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value[31:0], unsigned
   output logic [2:0]  rsp_tuser,   // event_res[2:0]
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam logic [bdc_pkg::QCNT_W-1:0] Q_ROOM =
      bdc_pkg::QCNT_W'(bdc_pkg::QDEPTH - bdc_pkg::MAX_EV);
   localparam logic [bdc_pkg::QCNT_W-1:0] Q_FULL =
      bdc_pkg::QCNT_W'(bdc_pkg::QDEPTH);

   bdc_pkg::cfg_type          cfg_ff, cfg_in;
   bdc_pkg::evt_type          push_ev [bdc_pkg::MAX_EV];
   bdc_pkg::front_status_type fr_st;
   bdc_pkg::evt_type          q_head;
   logic [bdc_pkg::QCNT_W-1:0] q_count;
   logic                      q_pop;
   logic                      req_fire;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            bdc_pkg::CSR_ACTIVE_HIGH: cfg_in.active_high       = csr_wdata[0];
            bdc_pkg::CSR_DEBOUNCE:    cfg_in.debounce_ticks    = csr_wdata;
            bdc_pkg::CSR_LONG_CLICK:  cfg_in.long_click_ticks  = csr_wdata;
            bdc_pkg::CSR_MULTI_CLICK: cfg_in.multi_click_ticks = csr_wdata;
            bdc_pkg::CSR_TICK_PERIOD: cfg_in.tick_period_ms    = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high       <= 1'b1;
         cfg_ff.debounce_ticks    <= 32'd5;
         cfg_ff.long_click_ticks  <= 32'd1000;
         cfg_ff.multi_click_ticks <= 32'd300;
         cfg_ff.tick_period_ms    <= 10'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept only while the queue can absorb the worst case of three events
   assign req_tready = !reset && (q_count <= Q_ROOM);
   assign req_fire   = req_tvalid && req_tready;

   bdc_front #(
      .TICK_BITS (TICK_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (req_fire),
      .in_cmd     (req_tuser),
      .in_now     (req_tdata[31:0]),
      .in_level   (req_tdata[32]),
      .in_read_ok (req_tdata[33]),
      .cfg        (cfg_ff),
      .push_ev    (push_ev),
      .status     (fr_st)
   );

   bdc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_n  (fr_st.push_n),
      .push_ev (push_ev),
      .pop     (q_pop),
      .head    (q_head),
      .count   (q_count)
   );

   bdc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_empty        (q_count == '0),
      .tick_period_ms (cfg_ff.tick_period_ms),
      .pop            (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast)
   );

   // queue never overfills given the ready rule
   `BDC_ASSERT(a_queue_bound, clock, reset, q_count <= Q_FULL)
   // a third short click is flushed at once and never held
   `BDC_ASSERT(a_no_held_triple, clock, reset, fr_st.pending != 2'd3)
   // events from an accepted item land in the queue
   `BDC_ASSERT_NEXT(a_push_lands, clock, reset, req_fire && (fr_st.push_n != 2'd0), q_count != '0)

endmodule

>>> design/bdc_front.sv
// front end: debounce state, click counting and event classification
// depends on bdc_pkg; pushes up to three events per item into the queue
module bdc_front #(
   parameter int TICK_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_fire,
   input  logic [1:0]                in_cmd,
   input  logic [31:0]               in_now,
   input  logic                      in_level,
   input  logic                      in_read_ok,
   input  bdc_pkg::cfg_type          cfg,
   output bdc_pkg::evt_type          push_ev [bdc_pkg::MAX_EV],
   output bdc_pkg::front_status_type status
);

   localparam int CMP_W = (TICK_BITS > 32) ? TICK_BITS : 32;

   logic                 stable_ff, stable_in;
   logic                 raw_ff, raw_in;
   logic [TICK_BITS-1:0] rct_ff, rct_in;
   logic [TICK_BITS-1:0] pst_ff, pst_in;
   logic [TICK_BITS-1:0] lrt_ff, lrt_in;
   logic [1:0]           pend_ff, pend_in;

   logic [TICK_BITS-1:0] now_t;
   logic [TICK_BITS-1:0] held_t;
   logic                 pressed;
   logic [1:0]           pend_inc;
   logic [1:0]           n;
   bdc_pkg::evt_type     ev [bdc_pkg::MAX_EV];
   bdc_pkg::evt_type     e_new;

   // wrap-safe elapsed-time compare
   function automatic logic elapsed(input logic [TICK_BITS-1:0] a,
                                    input logic [TICK_BITS-1:0] b,
                                    input logic [31:0] intv);
      logic [TICK_BITS-1:0] d;
      d = a - b;
      return CMP_W'(d) >= CMP_W'(intv);
   endfunction

   assign now_t  = TICK_BITS'(in_now);
   assign held_t = now_t - pst_ff;

   always_comb begin
      stable_in = stable_ff;
      raw_in    = raw_ff;
      rct_in    = rct_ff;
      pst_in    = pst_ff;
      lrt_in    = lrt_ff;
      pend_in   = pend_ff;
      pend_inc  = pend_ff;
      n         = 2'd0;
      e_new     = '0;
      for (int k = 0; k < bdc_pkg::MAX_EV; k++) begin
         ev[k] = '0;
      end
      pressed = cfg.active_high ? in_level : ~in_level;

      if (in_fire) begin
         unique case (bdc_pkg::cmd_type'(in_cmd))
            bdc_pkg::CMD_RESYNC: begin
               stable_in = in_read_ok & pressed;
               raw_in    = in_read_ok & pressed;
               rct_in    = now_t;
               pst_in    = now_t;
               lrt_in    = now_t;
               pend_in   = 2'd0;
            end
            bdc_pkg::CMD_CLEAR: begin
               stable_in = 1'b0;
               raw_in    = 1'b0;
               pend_in   = 2'd0;
            end
            bdc_pkg::CMD_SAMPLE: begin
               if (in_read_ok) begin
                  if (pressed != raw_ff) begin
                     raw_in = pressed;
                     rct_in = now_t;
                  end
                  if ((raw_in != stable_ff) &&
                      elapsed(now_t, rct_in, cfg.debounce_ticks)) begin
                     stable_in = raw_in;
                     if (raw_in) begin
                        // a new press after the window closes the old run
                        if ((pend_ff != 2'd0) &&
                            elapsed(rct_in, lrt_ff, cfg.multi_click_ticks)) begin
                           if (n < 2'd3) begin
                              ev[n] = bdc_pkg::flush_event(pend_ff);
                              n = n + 2'd1;
                           end
                           pend_in = 2'd0;
                        end
                        pst_in     = now_t;
                        e_new.code = bdc_pkg::EV_PRESSED;
                        e_new.data = 32'd1;
                        if (n < 2'd3) begin
                           ev[n] = e_new;
                           n = n + 2'd1;
                        end
                     end else begin
                        e_new.code = bdc_pkg::EV_RELEASED;
                        e_new.data = 32'd0;
                        if (n < 2'd3) begin
                           ev[n] = e_new;
                           n = n + 2'd1;
                        end
                        if (elapsed(now_t, pst_ff, cfg.long_click_ticks)) begin
                           if (pend_ff != 2'd0) begin
                              if (n < 2'd3) begin
                                 ev[n] = bdc_pkg::flush_event(pend_ff);
                                 n = n + 2'd1;
                              end
                           end
                           pend_in    = 2'd0;
                           e_new.code = bdc_pkg::EV_LONG;
                           e_new.data = 32'(held_t);
                           if (n < 2'd3) begin
                              ev[n] = e_new;
                              n = n + 2'd1;
                           end
                        end else begin
                           pend_inc = (pend_ff == 2'd3) ? pend_ff : pend_ff + 2'd1;
                           lrt_in   = now_t;
                           if (pend_inc == 2'd3) begin
                              if (n < 2'd3) begin
                                 ev[n] = bdc_pkg::flush_event(pend_inc);
                                 n = n + 2'd1;
                              end
                              pend_in = 2'd0;
                           end else begin
                              pend_in = pend_inc;
                           end
                        end
                     end
                  end
                  // multi-click window expired while released
                  if ((pend_in != 2'd0) && !stable_in && !raw_in &&
                      elapsed(now_t, lrt_in, cfg.multi_click_ticks)) begin
                     if (n < 2'd3) begin
                        ev[n] = bdc_pkg::flush_event(pend_in);
                        n = n + 2'd1;
                     end
                     pend_in = 2'd0;
                  end
               end
            end
            default: ;
         endcase
      end

      if (n != 2'd0) begin
         ev[n - 2'd1].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         raw_ff    <= 1'b0;
         rct_ff    <= '0;
         pst_ff    <= '0;
         lrt_ff    <= '0;
         pend_ff   <= 2'd0;
      end else begin
         stable_ff <= stable_in;
         raw_ff    <= raw_in;
         rct_ff    <= rct_in;
         pst_ff    <= pst_in;
         lrt_ff    <= lrt_in;
         pend_ff   <= pend_in;
      end
   end

   assign push_ev        = ev;
   assign status.push_n  = n;
   assign status.pending = pend_ff;

endmodule

>>> design/bdc_fifo.sv
// event queue between front and back, takes up to three items per cycle
// depends on bdc_pkg for the event type and depth constants
module bdc_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        push_n,
   input  bdc_pkg::evt_type                  push_ev [bdc_pkg::MAX_EV],
   input  logic                              pop,
   output bdc_pkg::evt_type                  head,
   output logic [bdc_pkg::QCNT_W-1:0]        count
);

   localparam int PW = bdc_pkg::QPTR_W;
   localparam int CW = bdc_pkg::QCNT_W;

   bdc_pkg::evt_type mem [bdc_pkg::QDEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign wr_ptr_in = wr_ptr_ff + PW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push_n) - CW'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < bdc_pkg::MAX_EV; k++) begin
         if (2'(k) < push_n) begin
            mem[wr_ptr_ff + PW'(k)] <= push_ev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign count = count_ff;

endmodule

>>> design/bdc_back.sv
// back end: output register, scales long-click duration to ms
// depends on bdc_pkg; drains the event queue one item per cycle unless rsp_tready stalls it
module bdc_back (
   input  logic             clock,
   input  logic             reset,
   input  bdc_pkg::evt_type head,
   input  logic             q_empty,
   input  logic [9:0]       tick_period_ms,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  code_ff, code_in;
   logic        last_ff, last_in;
   logic [31:0] prod;

   assign pop  = !q_empty && (!valid_ff || rsp_tready);
   // duration in ms wraps modulo 2^32
   assign prod = head.data * 32'(tick_period_ms);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      code_in  = code_ff;
      last_in  = last_ff;
      if (pop) begin
         valid_in = 1'b1;
         value_in = (head.code == bdc_pkg::EV_LONG) ? prod : head.data;
         code_in  = head.code;
         last_in  = head.last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = code_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> sim/button_debounce_click_classifier_top_tb.sv
// self-checking bench for button_debounce_click_classifier_top
// holds its own debounce and click predictor; needs bdc_pkg and the rtl only
`timescale 1ns / 1ps

module button_debounce_click_classifier_top_tb;

   // command code the block must ignore
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   // quiet cycles before the run is declared hung
   localparam int WATCHDOG_LIMIT = 4000;
   // first event leaves via the queue and the output register; wait a bit longer when idle
   localparam int DRAIN_CYCLES = 6;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] stamp;
      logic        lvl;
      logic        ok;
   } sample_type;

   typedef struct {
      bdc_pkg::evt_code_type code;
      logic [31:0]           value;
      logic                  last;
   } click_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;     // now[31:0], level[32], read_ok[33], zero pad
   logic [1:0]  req_tuser = bdc_pkg::CMD_SAMPLE;  // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // value[31:0], unsigned
   logic [2:0]  rsp_tuser;          // event_res[2:0]
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   // stimulus side
   sample_type      sample_backlog[$];
   sample_type      drv_item;
   logic            req_taken = 1'b0;
   int              req_gap;
   int              rsp_stall;
   bit              req_idle_on;
   bit              rsp_idle_on;
   logic [31:0]     tnow;
   int              g_db, g_lc, g_mc;   // gesture timing, clamped from the registers

   // predictor side: register copy, debounce state and events still owed
   bdc_pkg::cfg_type model_cfg;
   logic            btn_stable, btn_raw;
   logic [31:0]     raw_edge_time, press_time, release_time;
   logic [1:0]      click_count;
   int              new_events;
   click_event_type due_events[$];
   click_event_type want;

   // bookkeeping
   int              items_queued, items_accepted, events_checked, settings_run;
   int              mismatches, quiet_cycles;
   int              code_hits[8];

   button_debounce_click_classifier_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // wrap-safe elapsed compare on the 32-bit tick count
   function automatic logic ticks_since(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] n);
      logic [31:0] d;
      d = a - b;
      return d >= n;
   endfunction

   // at most three events per item, extras are dropped
   task automatic add_event(input bdc_pkg::evt_code_type code, input logic [31:0] value);
      click_event_type e;
      if (new_events < bdc_pkg::MAX_EV) begin
         e.code  = code;
         e.value = value;
         e.last  = 1'b0;
         due_events.push_back(e);
         new_events++;
      end
   endtask

   task automatic flush_clicks();
      case (click_count)
         2'd1: add_event(bdc_pkg::EV_CLICKED, 32'd1);
         2'd2: add_event(bdc_pkg::EV_DOUBLE, 32'd2);
         2'd3: add_event(bdc_pkg::EV_TRIPLE, 32'd3);
         default: ;
      endcase
      click_count = 2'd0;
   endtask

   task automatic reset_model();
      model_cfg.active_high       = 1'b1;
      model_cfg.debounce_ticks    = 32'd5;
      model_cfg.long_click_ticks  = 32'd1000;
      model_cfg.multi_click_ticks = 32'd300;
      model_cfg.tick_period_ms    = 10'd1;
      btn_stable    = 1'b0;
      btn_raw       = 1'b0;
      raw_edge_time = '0;
      press_time    = '0;
      release_time  = '0;
      click_count   = 2'd0;
   endtask

   // work out the events one accepted item causes and queue them
   task automatic classify_item(input logic [1:0] cmd, input logic [31:0] stamp,
                                input logic lvl, input logic ok);
      logic        pressed;
      logic [31:0] held;
      logic [63:0] ms;
      pressed    = model_cfg.active_high ? lvl : ~lvl;
      new_events = 0;
      case (cmd)
         bdc_pkg::CMD_RESYNC: begin
            // a failed read resyncs to released
            btn_stable    = ok & pressed;
            btn_raw       = ok & pressed;
            raw_edge_time = stamp;
            press_time    = stamp;
            release_time  = stamp;
            click_count   = 2'd0;
         end
         bdc_pkg::CMD_CLEAR: begin
            // times are kept on disable
            btn_stable  = 1'b0;
            btn_raw     = 1'b0;
            click_count = 2'd0;
         end
         bdc_pkg::CMD_SAMPLE: if (ok) begin
            if (pressed != btn_raw) begin
               btn_raw       = pressed;
               raw_edge_time = stamp;
            end
            if (btn_raw != btn_stable &&
                ticks_since(stamp, raw_edge_time, model_cfg.debounce_ticks)) begin
               btn_stable = btn_raw;
               if (btn_raw) begin
                  // a press after the window closes the previous click group
                  if (click_count != 2'd0 &&
                      ticks_since(raw_edge_time, release_time, model_cfg.multi_click_ticks))
                     flush_clicks();
                  press_time = stamp;
                  add_event(bdc_pkg::EV_PRESSED, 32'd1);
               end else begin
                  held = stamp - press_time;
                  add_event(bdc_pkg::EV_RELEASED, 32'd0);
                  if (ticks_since(stamp, press_time, model_cfg.long_click_ticks)) begin
                     flush_clicks();
                     ms = held * model_cfg.tick_period_ms;
                     add_event(bdc_pkg::EV_LONG, ms[31:0]);
                  end else begin
                     if (click_count != 2'd3)
                        click_count = click_count + 2'd1;
                     release_time = stamp;
                     if (click_count == 2'd3)
                        flush_clicks();
                  end
               end
            end
            // multi-click window ran out while released
            if (click_count != 2'd0 && !btn_stable && !btn_raw &&
                ticks_since(stamp, release_time, model_cfg.multi_click_ticks))
               flush_clicks();
         end
         default: ;
      endcase
      if (new_events > 0)
         due_events[due_events.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, exp_val);
      mismatches++;
   endtask

   // accepts on both channels are seen at the rising edge; an item is
   // predicted first, although its events can never leave in the same cycle
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         items_accepted++;
         classify_item(req_tuser, req_tdata[31:0], req_tdata[32], req_tdata[33]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         code_hits[rsp_tuser]++;
         if (due_events.size() == 0) begin
            report_mismatch("event with nothing due, code", {29'd0, rsp_tuser}, '0);
         end else begin
            want = due_events.pop_front();
            events_checked++;
            if (rsp_tuser !== want.code)
               report_mismatch("event code", {29'd0, rsp_tuser}, {29'd0, want.code});
            if (rsp_tdata !== want.value)
               report_mismatch("event value", rsp_tdata, want.value);
            if (rsp_tlast !== want.last)
               report_mismatch("last flag", {31'd0, rsp_tlast}, {31'd0, want.last});
         end
      end
   end

   // hang detector: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d events still due",
                     WATCHDOG_LIMIT, due_events.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // driver and receiver, both change their outputs on the falling edge
   // ---------------------------------------------------------------

   // idle stretch length: mostly short, now and then long
   function automatic int idle_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   // hold the current item until accepted, then idle a while or take the next
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (sample_backlog.size() > 0) begin
            drv_item = sample_backlog.pop_front();
            req_tuser  <= drv_item.cmd;
            req_tdata  <= {6'd0, drv_item.ok, drv_item.lvl, drv_item.stamp};
            req_tvalid <= 1'b1;
            req_gap    <= (req_idle_on && $urandom_range(0, 1)) ? idle_len() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   task automatic queue_sample(input logic [1:0] cmd, input logic [31:0] stamp,
                               input logic lvl, input logic ok);
      sample_type s;
      s.cmd   = cmd;
      s.stamp = stamp;
      s.lvl   = lvl;
      s.ok    = ok;
      sample_backlog.push_back(s);
      items_queued++;
   endtask

   // one sample of the wanted button state, sometimes replaced by noise:
   // failed reads, stray commands, or a jump of the tick count
   task automatic queue_level(input logic pressed);
      int   r;
      logic lvl;
      r   = $urandom_range(0, 99);
      lvl = model_cfg.active_high ? pressed : ~pressed;
      if (r < 4) begin
         queue_sample(bdc_pkg::CMD_SAMPLE, tnow, 1'($urandom_range(0, 1)), 1'b0);
      end else if (r < 6) begin
         queue_sample(bdc_pkg::CMD_RESYNC, tnow, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end else if (r < 7) begin
         queue_sample(bdc_pkg::CMD_CLEAR, tnow, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end else if (r < 8) begin
         queue_sample(CMD_UNKNOWN, tnow, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (r < 9) begin
         tnow = $urandom;
         queue_sample(bdc_pkg::CMD_SAMPLE, tnow, lvl, 1'b1);
      end else begin
         queue_sample(bdc_pkg::CMD_SAMPLE, tnow, lvl, 1'b1);
      end
   endtask

   // contact bounce, then a few samples spread over dur ticks
   task automatic hold_level(input logic pressed, input int dur);
      int bounces, n, stride, i;
      bounces = $urandom_range(0, 2);
      n       = $urandom_range(2, 4);
      stride  = dur / n + 1;
      for (i = 0; i < bounces; i++) begin
         tnow = tnow + 1;
         queue_level(~pressed);
         tnow = tnow + 1;
         queue_level(pressed);
      end
      for (i = 0; i < n; i++) begin
         tnow = tnow + stride;
         queue_level(pressed);
      end
   endtask

   // one press and release: short or long hold, gap inside or past the window
   task automatic queue_gesture();
      int hold, gap;
      if ($urandom_range(0, 3) == 0)
         hold = g_lc + $urandom_range(0, g_lc / 2 + 4);
      else
         hold = $urandom_range(1, (g_lc > 2) ? g_lc - 1 : 1);
      if ($urandom_range(0, 1))
         gap = $urandom_range(1, (g_mc > 1) ? g_mc - 1 : 1);
      else
         gap = g_mc + $urandom_range(0, 10);
      hold_level(1'b1, g_db + hold);
      hold_level(1'b0, g_db + gap);
   endtask

   // wait until the sender is empty and every due event has come out
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (sample_backlog.size() != 0 || req_tvalid || due_events.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         bdc_pkg::CSR_ACTIVE_HIGH: model_cfg.active_high       = val[0];
         bdc_pkg::CSR_DEBOUNCE:    model_cfg.debounce_ticks    = val;
         bdc_pkg::CSR_LONG_CLICK:  model_cfg.long_click_ticks  = val;
         bdc_pkg::CSR_MULTI_CLICK: model_cfg.multi_click_ticks = val;
         bdc_pkg::CSR_TICK_PERIOD: model_cfg.tick_period_ms    = val[9:0];
         default: ;
      endcase
   endtask

   // huge register values get a modest gesture timing
   function automatic int gesture_scale(input logic [31:0] v);
      return (v > 32'd200) ? 24 : int'(v);
   endfunction

   // one register setting: program it while idle, then random gestures,
   // with a full drain halfway through
   task automatic run_phase(input logic act, input logic [31:0] db, input logic [31:0] lc,
                            input logic [31:0] mc, input logic [9:0] period,
                            input logic [31:0] start, input int quota, input bit idle_on);
      int target, halfway;
      bit paused;
      write_reg(bdc_pkg::CSR_ACTIVE_HIGH, {31'd0, act});
      write_reg(bdc_pkg::CSR_DEBOUNCE, db);
      write_reg(bdc_pkg::CSR_LONG_CLICK, lc);
      write_reg(bdc_pkg::CSR_MULTI_CLICK, mc);
      write_reg(bdc_pkg::CSR_TICK_PERIOD, {22'd0, period});
      @(negedge clock);
      csr_we      <= 1'b0;
      req_idle_on = idle_on;
      rsp_idle_on = idle_on;
      g_db    = gesture_scale(db);
      g_lc    = gesture_scale(lc);
      g_mc    = gesture_scale(mc);
      tnow    = start;
      target  = items_queued + quota;
      halfway = items_queued + quota / 2;
      paused  = 1'b0;
      while (items_queued < target) begin
         queue_gesture();
         if (!paused && items_queued >= halfway) begin
            paused = 1'b1;
            wait_drained();
         end
      end
      wait_drained();
      settings_run++;
   endtask

   initial begin
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part on the reset register values, no idling
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd0, 1'b1, 1'b0);     // failed read, ignored
      queue_sample(CMD_UNKNOWN, 32'd1, 1'b1, 1'b1);             // unknown command, ignored
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd10, 1'b1, 1'b1);    // raw edge
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd15, 1'b1, 1'b1);    // pressed
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd20, 1'b0, 1'b1);
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd25, 1'b0, 1'b1);    // released, one click pending
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd400, 1'b0, 1'b1);   // window over: clicked
      queue_sample(bdc_pkg::CMD_RESYNC, 32'd1000, 1'b1, 1'b1);  // resync straight to pressed
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1010, 1'b0, 1'b1);
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1015, 1'b0, 1'b1);  // released, first click
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1020, 1'b1, 1'b1);
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1025, 1'b1, 1'b1);  // pressed inside the window
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1030, 1'b0, 1'b1);
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1035, 1'b0, 1'b1);  // second click
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1040, 1'b1, 1'b1);
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd1045, 1'b1, 1'b1);  // pressed and held
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd2100, 1'b0, 1'b1);
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'd2105, 1'b0, 1'b1);  // released, double, long
      // failed read resyncs released
      queue_sample(bdc_pkg::CMD_RESYNC, 32'hFFFF_FFF0, 1'b1, 1'b0);
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'hFFFF_FFFC, 1'b1, 1'b1);
      // pressed across the wrap
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'h0000_0001, 1'b1, 1'b1);
      queue_sample(bdc_pkg::CMD_CLEAR, 32'd5, 1'b1, 1'b1);      // disable clears the press
      queue_sample(bdc_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1);
      queue_sample(bdc_pkg::CMD_RESYNC, 32'h8000_0000, 1'b1, 1'b1);
      wait_drained();
      settings_run++;

      // random part: small timings, then the register extremes
      run_phase(1'b1, 32'd3, 32'd40, 32'd20, 10'd7, $urandom, 60, 1'b1);
      run_phase(1'b0, 32'd0, 32'd25, 32'd0, 10'd1000, $urandom, 50, 1'b1);
      run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1, $urandom, 30, 1'b1);
      // every release is long, and with a zero period it lasts 0 ms
      run_phase(1'b1, 32'd2, 32'd0, 32'd15, 10'd0, $urandom, 40, 1'b0);
      // no window end and no long click: clicks pile up to triples; starts near wrap
      run_phase(1'b0, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd3, 32'hFFFF_FF80, 50, 1'b1);
      repeat (3)
         run_phase(1'($urandom_range(0, 1)), $urandom_range(0, 8), $urandom_range(10, 80),
                   $urandom_range(5, 60), 10'($urandom_range(1, 1000)), $urandom, 45,
                   1'($urandom_range(0, 1)));

      $display("covered %0d items under %0d register settings, %0d events checked",
               items_accepted, settings_run, events_checked);
      $display("events seen: pressed %0d released %0d clicked %0d long %0d double %0d triple %0d",
               code_hits[bdc_pkg::EV_PRESSED], code_hits[bdc_pkg::EV_RELEASED],
               code_hits[bdc_pkg::EV_CLICKED], code_hits[bdc_pkg::EV_LONG],
               code_hits[bdc_pkg::EV_DOUBLE], code_hits[bdc_pkg::EV_TRIPLE]);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> button_debounce_click_classifier_top.f
+incdir+design
design/bdc_pkg.sv
design/bdc_front.sv
design/bdc_fifo.sv
design/bdc_back.sv
design/button_debounce_click_classifier_top.sv
sim/button_debounce_click_classifier_top_tb.sv
